// ----- design/spmd_pkg.sv -----
// ----------------------------------------------------------------------------
// spmd_pkg
// Constants, codes and types for the per-task signal controller.
// ----------------------------------------------------------------------------
package spmd_pkg;

    // Number of signals handled (8 .. 32)
    localparam int unsigned SIG_CNT = 32;
    localparam int unsigned SIG_W   = $clog2(SIG_CNT);

    // Masks and the ignore bitmap are always 32 bits wide
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned MASK_IDX_W = 5;

    localparam logic [MASK_W-1:0] DFLT_IGN_RST = 32'h1082_0000;
    localparam logic [7:0]        EXIT_HI      = 8'd255;

    // Operation codes
    localparam logic [2:0] OP_SEND  = 3'd0;
    localparam logic [2:0] OP_PEEK  = 3'd1;
    localparam logic [2:0] OP_CHECK = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_MASK  = 3'd4;

    // Action table kinds
    localparam logic [1:0] KIND_IGNORE  = 2'd0;
    localparam logic [1:0] KIND_DEFAULT = 2'd1;
    localparam logic [1:0] KIND_HANDLER = 2'd2;

    // Reported actions
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_IGNORED   = 2'd1;
    localparam logic [1:0] ACT_TERMINATE = 2'd2;
    localparam logic [1:0] ACT_HANDLER   = 2'd3;

    typedef logic [SIG_CNT-1:0] t_sig_vec;

    typedef struct packed {
        logic [2:0]        op;
        logic [4:0]        sig;
        logic              blocked;
        logic              ended;
        logic [1:0]        kind;
        logic [MASK_W-1:0] haddr;
        logic [MASK_W-1:0] amask;
        logic [MASK_W-1:0] nmask;
    } t_item;

    typedef struct packed {
        logic              wake;
        logic              dropped;
        logic              found;
        logic [4:0]        taken;
        logic [1:0]        act;
        logic [15:0]       status;
        logic [MASK_W-1:0] haddr;
        logic [MASK_W-1:0] saved;
    } t_result;

endpackage

// ----- design/signal_pending_mask_delivery.sv -----
// ----------------------------------------------------------------------------
// signal_pending_mask_delivery
// Per-task signal controller: pending set, blocking mask, action table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one operation per beat (send, peek,
//   check, set action, write blocking mask). Output channel o_valid/i_ready
//   returns exactly one result beat per input beat, in order.
//   i_cfg_we/i_cfg_data load the default-ignore bitmap; write it only while
//   the block is idle.
//   Path: a beat accepted is captured in the input register; its result is
//   registered when the stage advances and shown on the output from then on.
//   Throughput: one beat per cycle while i_ready stays high. The decode, mask,
//   lowest-bit pick and one action table read sit in the single logic stage
//   between the input and result registers; state updates land with the result.
//   Stall: if the receiver holds i_ready low, the result register holds, the
//   input register keeps one more beat, then o_ready drops.
//   Reset: pending set and blocking mask clear, every action entry returns to
//   default, the ignore bitmap returns to child, urgent and window change.
//   Handler address and mask entries hold garbage until a handler is set.
// ----------------------------------------------------------------------------
module signal_pending_mask_delivery
    import spmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_operation,
    input  logic [4:0]        i_signal_number,
    input  logic              i_task_blocked,
    input  logic              i_task_ended,
    input  logic [1:0]        i_action_kind,
    input  logic [31:0]       i_handler_address,
    input  logic [31:0]       i_action_mask,
    input  logic [31:0]       i_new_blocking_mask,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_wake_task,
    output logic              o_dropped_ended,
    output logic              o_found,
    output logic [4:0]        o_taken_signal,
    output logic [1:0]        o_action_taken,
    output logic [15:0]       o_exit_status,
    output logic [31:0]       o_handler_out,
    output logic [31:0]       o_saved_mask,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data
);

    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    t_result           r_res;
    t_result           n_res;

    logic [MASK_W-1:0] r_dflt_ign;
    t_sig_vec          r_pend;
    t_sig_vec          n_pend;
    logic [MASK_W-1:0] r_bmask;
    logic [MASK_W-1:0] n_bmask;
    logic [1:0]        r_kind  [SIG_CNT];
    logic [MASK_W-1:0] r_haddr [SIG_CNT];
    logic [MASK_W-1:0] r_hmask [SIG_CNT];

    logic              adv;
    logic              kind_we;
    logic              hdl_we;
    logic [SIG_W-1:0]  idx_in;
    logic              in_range;
    t_sig_vec          ready_vec;
    t_sig_vec          low_oh;
    logic [SIG_W-1:0]  low_idx;
    t_sig_vec          acting;
    logic [1:0]        low_kind;

    // Stage advances when an item waits and the result slot is free or drains
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    // ---------------------------------------------------------------- input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.op      <= i_operation;
            r_in.sig     <= i_signal_number;
            r_in.blocked <= i_task_blocked;
            r_in.ended   <= i_task_ended;
            r_in.kind    <= i_action_kind;
            r_in.haddr   <= i_handler_address;
            r_in.amask   <= i_action_mask;
            r_in.nmask   <= i_new_blocking_mask;
        end
    end

    // ---------------------------------------------------------------- logic
    assign idx_in    = r_in.sig[SIG_W-1:0];
    assign in_range  = 32'(r_in.sig) < SIG_CNT;
    assign ready_vec = r_pend & ~r_bmask[SIG_CNT-1:0];
    // isolate lowest set bit
    assign low_oh    = ready_vec & (~ready_vec + t_sig_vec'(1));

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < SIG_CNT; i++) begin
            low_idx |= low_oh[i] ? SIG_W'(i) : '0;
        end
    end

    always_comb begin
        for (int i = 0; i < SIG_CNT; i++) begin
            acting[i] = ready_vec[i] && (r_kind[i] == KIND_HANDLER ||
                        (r_kind[i] == KIND_DEFAULT && !r_dflt_ign[i]));
        end
    end

    assign low_kind = r_kind[low_idx];

    always_comb begin
        n_res   = '0;
        n_pend  = r_pend;
        n_bmask = r_bmask;
        kind_we = 1'b0;
        hdl_we  = 1'b0;
        case (r_in.op)
            OP_SEND: begin
                if (in_range) begin
                    if (r_in.ended) begin
                        n_res.dropped = 1'b1;
                    end else begin
                        n_pend      = r_pend | (t_sig_vec'(1) << idx_in);
                        n_res.wake  = r_in.blocked && !r_bmask[MASK_IDX_W'(idx_in)];
                    end
                end
            end
            OP_PEEK: begin
                n_res.found = |acting;
            end
            OP_CHECK: begin
                if (|ready_vec) begin
                    n_pend[low_idx] = 1'b0;
                    n_res.found     = 1'b1;
                    n_res.taken     = 5'(low_idx);
                    if (low_kind == KIND_HANDLER) begin
                        n_res.act   = ACT_HANDLER;
                        n_res.haddr = r_haddr[low_idx];
                        n_res.saved = r_bmask;
                        n_bmask     = r_bmask | r_hmask[low_idx];
                    end else if (low_kind == KIND_DEFAULT &&
                                 !r_dflt_ign[MASK_IDX_W'(low_idx)]) begin
                        n_res.act    = ACT_TERMINATE;
                        n_res.status = {EXIT_HI, 8'(low_idx)};
                    end else begin
                        n_res.act = ACT_IGNORED;
                    end
                end
            end
            OP_SET: begin
                if (in_range &&
                    r_in.kind inside {KIND_IGNORE, KIND_DEFAULT, KIND_HANDLER}) begin
                    kind_we = 1'b1;
                    hdl_we  = (r_in.kind == KIND_HANDLER);
                end
            end
            OP_MASK: begin
                n_bmask = r_in.nmask;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_ign <= DFLT_IGN_RST;
            r_pend     <= '0;
            r_bmask    <= '0;
            for (int i = 0; i < SIG_CNT; i++) begin
                r_kind[i] <= KIND_DEFAULT;
            end
        end else begin
            if (i_cfg_we) begin
                r_dflt_ign <= i_cfg_data;
            end
            if (adv) begin
                r_pend  <= n_pend;
                r_bmask <= n_bmask;
                if (kind_we) begin
                    r_kind[idx_in] <= r_in.kind;
                end
            end
        end
    end

    // handler entries have no reset; read only after a handler write
    always_ff @(posedge i_clk) begin
        if (adv && hdl_we) begin
            r_haddr[idx_in] <= r_in.haddr;
            r_hmask[idx_in] <= r_in.amask;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_wake_task     = r_res.wake;
    assign o_dropped_ended = r_res.dropped;
    assign o_found         = r_res.found;
    assign o_taken_signal  = r_res.taken;
    assign o_action_taken  = r_res.act;
    assign o_exit_status   = r_res.status;
    assign o_handler_out   = r_res.haddr;
    assign o_saved_mask    = r_res.saved;

    // ---------------------------------------------------------------- checks
    a_check_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.op == OP_CHECK && n_res.found) |=> !r_pend[$past(low_idx)])
        else $error("taken signal still pending");

    a_mask_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.op == OP_MASK) |=> r_bmask == $past(r_in.nmask))
        else $error("blocking mask not loaded");

    a_act_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action_taken != ACT_NONE) |-> o_found)
        else $error("action reported without a taken signal");

    a_send_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_wake_task && o_dropped_ended))
        else $error("wake and drop together");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && r_res == $past(r_res)))
        else $error("result changed while stalled");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-task signal controller. A driver feeds
// operation beats from a queue and a monitor checks every result beat against
// an in-bench model of the pending set, blocking mask and action table.
// Phases step the default-ignore bitmap through its extremes, both sides idle
// at random, and one long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
    import spmd_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] KIND_BAD    = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AT     = 500;
    localparam int PHASE_ITEMS = 190;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    t_item       in_beat = '0;

    logic        o_ready, o_valid, o_wake_task, o_dropped_ended, o_found;
    logic [4:0]  o_taken_signal;
    logic [1:0]  o_action_taken;
    logic [15:0] o_exit_status;
    logic [31:0] o_handler_out, o_saved_mask;

    // model state
    logic [31:0] ign_set = DFLT_IGN_RST;
    logic [31:0] pend_set = '0;
    logic [31:0] blk_mask = '0;
    logic [1:0]  kind_tab [SIG_CNT];
    logic [31:0] hand_tab [SIG_CNT];
    logic [31:0] hmask_tab [SIG_CNT];

    t_item   op_q [$];
    t_result outcome_q [$];

    int items_queued = 0, beats_in = 0, beats_out = 0, err_cnt = 0;
    int idle_cycles = 0, tx_gap = 0, rx_stall = 0;
    bit in_accepted = 0, calm_phase = 0, long_hold_done = 0, saw_backpressure = 0;
    int n_send = 0, n_wake = 0, n_drop = 0, n_peek = 0, n_peek_hit = 0, n_write = 0;
    int n_handler = 0, n_term = 0, n_ign = 0, n_empty = 0, n_cfg = 0;

    signal_pending_mask_delivery dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_ready            (o_ready),
        .i_operation        (in_beat.op),
        .i_signal_number    (in_beat.sig),
        .i_task_blocked     (in_beat.blocked),
        .i_task_ended       (in_beat.ended),
        .i_action_kind      (in_beat.kind),
        .i_handler_address  (in_beat.haddr),
        .i_action_mask      (in_beat.amask),
        .i_new_blocking_mask(in_beat.nmask),
        .o_valid            (o_valid),
        .i_ready            (out_ready),
        .o_wake_task        (o_wake_task),
        .o_dropped_ended    (o_dropped_ended),
        .o_found            (o_found),
        .o_taken_signal     (o_taken_signal),
        .o_action_taken     (o_action_taken),
        .o_exit_status      (o_exit_status),
        .o_handler_out      (o_handler_out),
        .o_saved_mask       (o_saved_mask),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one beat to the model and returns the result it must produce.
    function automatic t_result signal_outcome(t_item it);
        t_result res;
        logic [31:0] live;
        int s;
        bit hit;
        res = '0;
        case (it.op)
            OP_SEND: begin
                n_send++;
                if (it.ended) begin
                    res.dropped = 1'b1;
                    n_drop++;
                end else begin
                    pend_set[it.sig] = 1'b1;
                    if (!blk_mask[it.sig] && it.blocked) begin
                        res.wake = 1'b1;
                        n_wake++;
                    end
                end
            end
            OP_PEEK: begin
                n_peek++;
                live = pend_set & ~blk_mask;
                hit = 0;
                for (s = 0; s < SIG_CNT; s++) begin
                    if (live[s] && (kind_tab[s] == KIND_HANDLER ||
                                    (kind_tab[s] == KIND_DEFAULT && !ign_set[s])))
                        hit = 1;
                end
                res.found = hit;
                if (hit) n_peek_hit++;
            end
            OP_CHECK: begin
                live = pend_set & ~blk_mask;
                if (live == '0) begin
                    n_empty++;
                end else begin
                    s = 0;
                    while (!live[s]) s++;
                    pend_set[s] = 1'b0;
                    res.found = 1'b1;
                    res.taken = s[4:0];
                    if (kind_tab[s] == KIND_HANDLER) begin
                        res.act   = ACT_HANDLER;
                        res.haddr = hand_tab[s];
                        res.saved = blk_mask;
                        blk_mask  = blk_mask | hmask_tab[s];
                        n_handler++;
                    end else if (kind_tab[s] == KIND_DEFAULT && !ign_set[s]) begin
                        res.act    = ACT_TERMINATE;
                        res.status = {EXIT_HI, 3'b000, s[4:0]};
                        n_term++;
                    end else begin
                        res.act = ACT_IGNORED;
                        n_ign++;
                    end
                end
            end
            OP_SET: begin
                n_write++;
                if (it.kind != KIND_BAD) begin
                    kind_tab[it.sig] = it.kind;
                    if (it.kind == KIND_HANDLER) begin
                        hand_tab[it.sig]  = it.haddr;
                        hmask_tab[it.sig] = it.amask;
                    end
                end
            end
            OP_MASK: begin
                n_write++;
                blk_mask = it.nmask;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(string what);
        if (err_cnt < 40)
            $display("%0t: beat %0d: %s", $realtime, beats_out, what);
        err_cnt++;
    endtask

    task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Mostly short gaps, the odd long one; none during a calm phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Masks kept sparse so that signals keep getting through.
    function automatic logic [31:0] sparse_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return 32'd1 << $urandom_range(0, 31);
            7:          return (32'd1 << $urandom_range(0, 31)) |
                               (32'd1 << $urandom_range(0, 31));
            8:          return $urandom;
            default:    return $urandom & $urandom;
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 34)      it.op = OP_SEND;
        else if (r < 44) it.op = OP_PEEK;
        else if (r < 68) it.op = OP_CHECK;
        else if (r < 82) it.op = OP_SET;
        else if (r < 94) it.op = OP_MASK;
        else             it.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        it.sig     = 5'($urandom_range(0, 31));
        it.blocked = 1'($urandom_range(0, 1));
        it.ended   = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 20)      it.kind = KIND_IGNORE;
        else if (r < 50) it.kind = KIND_DEFAULT;
        else if (r < 95) it.kind = KIND_HANDLER;
        else             it.kind = KIND_BAD;
        it.haddr = $urandom;
        it.amask = (it.op == OP_SET) ? sparse_word() : $urandom;
        it.nmask = (it.op == OP_MASK) ? sparse_word() : $urandom;
        return it;
    endfunction

    function automatic t_item mk(logic [2:0] op, logic [4:0] sig, logic blk, logic ended,
                                 logic [1:0] kind, logic [31:0] haddr,
                                 logic [31:0] amask, logic [31:0] nmask);
        t_item it;
        it = '{op, sig, blk, ended, kind, haddr, amask, nmask};
        return it;
    endfunction

    task automatic queue_beat(t_item it);
        op_q.insert(op_q.size(), it);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (beats_in != items_queued || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_ignore_set(logic [31:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        ign_set  = value;
        n_cfg++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // sender
    always @(negedge i_clk) begin
        if (rst_n && (!in_valid || in_accepted)) begin
            in_accepted = 0;
            if (tx_gap > 0) begin
                in_valid <= 1'b0;
                tx_gap--;
            end else if (op_q.size() != 0) begin
                in_beat  <= op_q[0];
                op_q.delete(0);
                in_valid <= 1'b1;
                tx_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold partway through
    always @(negedge i_clk) begin
        if (rst_n) begin
            if (!long_hold_done && beats_in >= HOLD_AT) begin
                long_hold_done = 1;
                rx_stall = HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                out_ready <= 1'b0;
                rx_stall--;
            end else begin
                out_ready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        bit moved;
        if (rst_n) begin
            moved = 0;
            if (in_valid && o_ready) begin
                outcome_q.insert(outcome_q.size(), signal_outcome(in_beat));
                beats_in++;
                in_accepted = 1;
                moved = 1;
            end
            if (in_valid && !o_ready && long_hold_done)
                saw_backpressure = 1;
            if (o_valid && out_ready) begin
                moved = 1;
                if (outcome_q.size() == 0) begin
                    note_mismatch("result beat with nothing outstanding");
                end else begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    cmp_field("wake_task", 32'(o_wake_task), 32'(want.wake));
                    cmp_field("dropped_ended", 32'(o_dropped_ended), 32'(want.dropped));
                    cmp_field("found", 32'(o_found), 32'(want.found));
                    cmp_field("taken_signal", 32'(o_taken_signal), 32'(want.taken));
                    cmp_field("action_taken", 32'(o_action_taken), 32'(want.act));
                    cmp_field("exit_status", 32'(o_exit_status), 32'(want.status));
                    cmp_field("handler_out", o_handler_out, want.haddr);
                    cmp_field("saved_mask", o_saved_mask, want.saved);
                end
                beats_out++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int ph, k;
        logic [31:0] ign_val;
        for (k = 0; k < SIG_CNT; k++) begin
            kind_tab[k]  = KIND_DEFAULT;
            hand_tab[k]  = '0;
            hmask_tab[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: empty queries, wake/drop, default actions, handler entry,
        // masking, bad kind, spare opcodes
        queue_beat(mk(OP_PEEK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SEND, 5'd0, 1'b1, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SEND, 5'd31, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SEND, 5'd5, 1'b1, 1'b1, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SEND, 5'd17, 1'b1, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_PEEK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SET, 5'd3, 1'b0, 1'b0, KIND_HANDLER, '1, 32'h0000_0F00, '0));
        queue_beat(mk(OP_SET, 5'd4, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SET, 5'd6, 1'b0, 1'b0, KIND_BAD, '1, '1, '0));
        queue_beat(mk(OP_MASK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, 32'h0000_0002));
        queue_beat(mk(OP_SEND, 5'd1, 1'b1, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SEND, 5'd3, 1'b1, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_PEEK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_MASK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '1));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_MASK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_CHECK, 5'd0, 1'b0, 1'b0, KIND_IGNORE, '0, '0, '0));
        queue_beat(mk(OP_SET, 5'd3, 1'b0, 1'b0, KIND_DEFAULT, '0, '0, '0));
        queue_beat(mk(OP_SPARE_LO, 5'd31, 1'b1, 1'b1, KIND_BAD, '1, '1, '1));
        queue_beat(mk(OP_SPARE_LO + 3'd1, 5'd31, 1'b1, 1'b1, KIND_BAD, '1, '1, '1));
        queue_beat(mk(OP_SPARE_HI, 5'd31, 1'b1, 1'b1, KIND_BAD, '1, '1, '1));

        for (ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0:       ign_val = '0;
                1:       ign_val = '1;
                3:       ign_val = DFLT_IGN_RST;
                default: ign_val = $urandom;
            endcase
            load_ignore_set(ign_val);
            calm_phase = (ph == 1);
            repeat (PHASE_ITEMS) queue_beat(rand_item());
        end
        wait_drained();

        $display("covered %0d beats over %0d ignore-bitmap settings: %0d sends %s",
                 beats_in, n_cfg, n_send,
                 $sformatf("(%0d woke, %0d dropped), %0d peeks (%0d hit), %0d writes",
                           n_wake, n_drop, n_peek, n_peek_hit, n_write));
        $display("checks: %0d handler runs, %0d terminations, %0d ignored, %0d empty; %s",
                 n_handler, n_term, n_ign, n_empty,
                 $sformatf("input backpressured by long hold: %0d", saw_backpressure));
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
